FILE: sv/rgc_pkg.sv
// shared types and constants of the retract gear controller
`timescale 1ns / 1ps

package rgc_pkg;

  // event kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_PULSE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_FAULT   = 2'd2,
    OP_STARTUP = 2'd3
  } op_e;

  // gear position codes as reported on the result
  typedef enum logic [2:0] {
    GEAR_INIT    = 3'd0,
    GEAR_OPENING = 3'd1,
    GEAR_OPENED  = 3'd2,
    GEAR_CLOSING = 3'd3,
    GEAR_CLOSED  = 3'd4
  } gear_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_OPEN  = 2'd1,
    REQ_CLOSE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_DONE  = 2'd2
  } phase_e;

  // h-bridge drive patterns for both arms
  localparam logic [3:0] PINS_OPEN  = 4'h5;
  localparam logic [3:0] PINS_CLOSE = 4'hA;
  localparam logic [3:0] PINS_ARM1  = 4'h3;
  localparam logic [3:0] PINS_ARM2  = 4'hC;

  // configuration register indexes
  localparam logic [2:0] CFG_CLOSE_THR = 3'd0;
  localparam logic [2:0] CFG_OPEN_THR  = 3'd1;
  localparam logic [2:0] CFG_NEU_LOW   = 3'd2;
  localparam logic [2:0] CFG_NEU_HIGH  = 3'd3;
  localparam logic [2:0] CFG_REQ_DELAY = 3'd4;
  localparam logic [2:0] CFG_FS_TICKS  = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT   = 3'd6;

  typedef struct packed {
    logic [15:0] close_thr;
    logic [15:0] open_thr;
    logic [15:0] neu_low;
    logic [15:0] neu_high;
    logic [7:0]  req_delay;
    logic [7:0]  fs_ticks;
    logic [15:0] timeout;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    close_thr: 16'd1200,
    open_thr:  16'd1700,
    neu_low:   16'd1450,
    neu_high:  16'd1550,
    req_delay: 8'd5,
    fs_ticks:  8'd30,
    timeout:   16'd50
  };

  typedef struct packed {
    op_e         op;
    logic [15:0] pw;
    logic        arm;
  } item_t;

  typedef struct packed {
    phase_e     phase;
    req_e       pending;
    logic       sense;
    logic [3:0] pins;
    gear_e      gear;
  } result_t;

  localparam logic [8:0] CNT9_MAX   = 9'd511;
  localparam logic [15:0] CNT16_MAX = 16'hFFFF;

endpackage

FILE: sv/retract_gear_controller.sv
// top level of the retract gear controller
//
// channel   dir  width  contents
// s_axis    in   24+2   tdata: pulse_width, fault_arm; tuser: operation
// m_axis    out  16     tdata: gear_state, motor_pins, sense_enable,
//                       pending_request, startup_phase
// cfg       in   3+16   register index and write data, write on cfg_we_i
//
// one item per cycle sustained while the result side is not stalled
// the event register feeds the update logic, whose result lands in the output
// register in the same cycle the gear state registers take their new values
// reset clears the valid flags and the gear state and loads the default thresholds and delays
// a stalled result holds in the output register; one more item waits in the
// event register, and the input stalls only when both are full
`timescale 1ns / 1ps

module retract_gear_controller
  import rgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] pulse_width, [16] fault_arm, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [2:0] gear_state, [6:3] motor_pins,
                                     // [7] sense_enable, [9:8] pending_request,
                                     // [11:10] startup_phase, rest zero
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  logic    step_en;
  logic    s_accept;
  result_t result;
  result_t out_q;
  logic    out_valid_q;

  // the event register is processed when the result register is free or draining
  assign step_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_en;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  rgc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rgc_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (step_en),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (step_en) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q <= '{op: op_e'(s_axis_tuser), pw: s_axis_tdata[15:0], arm: s_axis_tdata[16]};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

endmodule

FILE: sv/rgc_cfg.sv
// configuration register file of the retract gear controller
`timescale 1ns / 1ps

module rgc_cfg
  import rgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLOSE_THR: cfg_q.close_thr <= cfg_data_i;
        CFG_OPEN_THR:  cfg_q.open_thr  <= cfg_data_i;
        CFG_NEU_LOW:   cfg_q.neu_low   <= cfg_data_i;
        CFG_NEU_HIGH:  cfg_q.neu_high  <= cfg_data_i;
        CFG_REQ_DELAY: cfg_q.req_delay <= cfg_data_i[7:0];
        CFG_FS_TICKS:  cfg_q.fs_ticks  <= cfg_data_i[7:0];
        CFG_TIMEOUT:   cfg_q.timeout   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/rgc_step.sv
// gear state registers and the per-event update logic
`timescale 1ns / 1ps

module rgc_step
  import rgc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  gear_e       mode_q, mode_d;
  logic [3:0]  pins_q, pins_d;
  logic        sense_q, sense_d;
  req_e        req_q, req_d;
  logic [8:0]  req_cnt_q, req_cnt_d;
  logic [15:0] mot_cnt_q, mot_cnt_d;
  logic [8:0]  lost_cnt_q, lost_cnt_d;
  phase_e      phase_q, phase_d;
  logic        first_seen_q, first_seen_d;
  logic [15:0] first_pw_q, first_pw_d;
  logic [15:0] last_pw_q, last_pw_d;
  logic        fire;
  logic        gate;

  always_comb begin
    mode_d       = mode_q;
    pins_d       = pins_q;
    sense_d      = sense_q;
    req_d        = req_q;
    req_cnt_d    = req_cnt_q;
    mot_cnt_d    = mot_cnt_q;
    lost_cnt_d   = lost_cnt_q;
    phase_d      = phase_q;
    first_seen_d = first_seen_q;
    first_pw_d   = first_pw_q;
    last_pw_d    = last_pw_q;
    fire         = 1'b0;
    gate         = 1'b0;

    case (item_i.op)
      OP_PULSE: begin
        if (!first_seen_d) begin
          first_pw_d   = item_i.pw;
          first_seen_d = 1'b1;
        end
        last_pw_d = item_i.pw;
        if (first_pw_d > cfg_i.open_thr && item_i.pw < cfg_i.close_thr) begin
          first_pw_d = '0;
        end
        gate = (first_pw_d < cfg_i.close_thr) &&
               (phase_d == PH_DONE || phase_d == PH_IDLE);
        if (gate) begin
          case (mode_d)
            GEAR_INIT: begin
              if (phase_d == PH_IDLE) begin
                phase_d = PH_FIRST;
                if (req_d != REQ_CLOSE) begin
                  req_cnt_d = '0;
                  req_d     = REQ_CLOSE;
                end
              end
            end
            GEAR_OPENED: begin
              if (item_i.pw < cfg_i.close_thr && req_d != REQ_CLOSE) begin
                req_cnt_d = '0;
                req_d     = REQ_CLOSE;
              end
            end
            GEAR_CLOSED: begin
              if (item_i.pw > cfg_i.open_thr && req_d != REQ_OPEN) begin
                req_cnt_d = '0;
                req_d     = REQ_OPEN;
              end
            end
            GEAR_OPENING: begin
              // reversal: stop first, then queue the close
              if (item_i.pw < cfg_i.close_thr) begin
                pins_d  = '0;
                sense_d = 1'b0;
                mode_d  = GEAR_OPENED;
                if (req_d != REQ_CLOSE) begin
                  req_cnt_d = '0;
                  req_d     = REQ_CLOSE;
                end
              end
            end
            default: begin
              if (item_i.pw > cfg_i.open_thr) begin
                pins_d  = '0;
                sense_d = 1'b0;
                mode_d  = GEAR_CLOSED;
                if (phase_d == PH_FIRST) begin
                  phase_d = PH_DONE;
                end
                if (req_d != REQ_OPEN) begin
                  req_cnt_d = '0;
                  req_d     = REQ_OPEN;
                end
              end
            end
          endcase
        end
      end

      OP_TICK: begin
        if (req_d == REQ_OPEN || req_d == REQ_CLOSE) begin
          fire = req_cnt_d > {1'b0, cfg_i.req_delay};
          if (req_cnt_d < CNT9_MAX) begin
            req_cnt_d = req_cnt_d + 9'd1;
          end
          if (fire) begin
            mot_cnt_d = '0;
            sense_d   = 1'b1;
            if (req_d == REQ_CLOSE) begin
              mode_d = GEAR_CLOSING;
              pins_d = PINS_CLOSE;
            end else begin
              mode_d = GEAR_OPENING;
              pins_d = PINS_OPEN;
            end
            req_d = REQ_NONE;
          end
        end
        if (mode_d == GEAR_OPENING || mode_d == GEAR_CLOSING) begin
          if (mot_cnt_d < CNT16_MAX) begin
            mot_cnt_d = mot_cnt_d + 16'd1;
          end
          if (mot_cnt_d >= cfg_i.timeout) begin
            pins_d  = '0;
            sense_d = 1'b0;
            if (mode_d == GEAR_CLOSING) begin
              mode_d = GEAR_CLOSED;
              if (phase_d == PH_FIRST) begin
                phase_d = PH_DONE;
              end
            end else begin
              mode_d = GEAR_OPENED;
            end
          end
        end
        // neutral pulse means the radio link is lost
        if (last_pw_d < cfg_i.neu_high && last_pw_d > cfg_i.neu_low) begin
          if (lost_cnt_d > {1'b0, cfg_i.fs_ticks}) begin
            if (req_d != REQ_CLOSE && mode_d != GEAR_CLOSING &&
                mode_d != GEAR_CLOSED) begin
              if (mode_d == GEAR_OPENING) begin
                pins_d  = '0;
                sense_d = 1'b0;
                mode_d  = GEAR_OPENED;
              end
              req_cnt_d = '0;
              req_d     = REQ_CLOSE;
            end
          end else if (lost_cnt_d < CNT9_MAX) begin
            lost_cnt_d = lost_cnt_d + 9'd1;
          end
        end else begin
          lost_cnt_d = '0;
        end
      end

      OP_FAULT: begin
        pins_d = pins_d & (item_i.arm ? PINS_ARM1 : PINS_ARM2);
        if (pins_d == '0) begin
          sense_d = 1'b0;
          if (mode_d == GEAR_CLOSING) begin
            mode_d = GEAR_CLOSED;
            if (phase_d == PH_FIRST) begin
              phase_d = PH_DONE;
            end
          end else if (mode_d == GEAR_OPENING) begin
            mode_d = GEAR_OPENED;
          end
        end
      end

      default: begin
        if (mode_d == GEAR_INIT && phase_d == PH_IDLE) begin
          phase_d = PH_FIRST;
          if (req_d != REQ_CLOSE) begin
            req_cnt_d = '0;
            req_d     = REQ_CLOSE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= GEAR_INIT;
      pins_q       <= '0;
      sense_q      <= 1'b0;
      req_q        <= REQ_NONE;
      req_cnt_q    <= '0;
      mot_cnt_q    <= '0;
      lost_cnt_q   <= '0;
      phase_q      <= PH_IDLE;
      first_seen_q <= 1'b0;
      first_pw_q   <= '0;
      last_pw_q    <= '0;
    end else if (en_i) begin
      mode_q       <= mode_d;
      pins_q       <= pins_d;
      sense_q      <= sense_d;
      req_q        <= req_d;
      req_cnt_q    <= req_cnt_d;
      mot_cnt_q    <= mot_cnt_d;
      lost_cnt_q   <= lost_cnt_d;
      phase_q      <= phase_d;
      first_seen_q <= first_seen_d;
      first_pw_q   <= first_pw_d;
      last_pw_q    <= last_pw_d;
    end
  end

  assign result_o = '{
    phase:   phase_d,
    pending: req_d,
    sense:   sense_d,
    pins:    pins_d,
    gear:    mode_d
  };

endmodule

FILE: sv/rgc_checker.sv
// port-level checks of the retract gear controller and their bind
`timescale 1ns / 1ps

module rgc_checker
  import rgc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic [2:0] gear;
  logic [3:0] pins;
  logic       sense;
  logic [1:0] pending;
  logic [1:0] phase;

  assign gear    = m_axis_tdata[2:0];
  assign pins    = m_axis_tdata[6:3];
  assign sense   = m_axis_tdata[7];
  assign pending = m_axis_tdata[9:8];
  assign phase   = m_axis_tdata[11:10];

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no h-bridge is ever driven both ways
  a_no_shoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(pins[0] && pins[1]) && !(pins[2] && pins[3]))
    else $error("h-bridge shoot-through");

  // sensing runs exactly while some pin is driven
  a_sense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> sense == (pins != 4'd0))
    else $error("sense enable out of step with pins");

  // pins are only driven while moving
  a_pins_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && pins != 4'd0 |-> gear == GEAR_OPENING || gear == GEAR_CLOSING)
    else $error("pins driven while not moving");

  // the first close is either pending from init or running
  a_first_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && phase == PH_FIRST |->
      (gear == GEAR_INIT && pending == REQ_CLOSE) || gear == GEAR_CLOSING)
    else $error("startup close lost");

endmodule

bind retract_gear_controller rgc_checker u_rgc_checker (.*);

FILE: tb/tb.sv
// self-checking testbench for the retract gear controller
`timescale 1ns / 1ps

module tb;
  import rgc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;
  // index past the last register, the block must ignore it
  localparam logic [2:0] CFG_SPARE = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] pulse_width, [16] fault_arm
  logic [1:0]  s_axis_tuser;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [2:0] gear_state, [6:3] motor_pins, [7] sense_enable,
                               // [9:8] pending_request, [11:10] startup_phase
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  retract_gear_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // events waiting to be sent and gear status words waiting to come back
  item_t   event_q[$];
  result_t status_q[$];

  int err_cnt;
  int cyc;
  int tx_idle_pct;
  int rx_stall_pct;
  int tx_burst;
  int rx_burst;

  // shadow copy of the controller: settings and gear state
  cfg_t        cfg_m;
  gear_e       gear_m;
  logic [3:0]  pins_m;
  logic        sense_m;
  req_e        req_m;
  logic [8:0]  req_cnt;
  logic [15:0] mot_cnt;
  logic [8:0]  lost_cnt;
  phase_e      phase_m;
  logic        seen_m;
  logic [15:0] first_m;
  logic [15:0] last_m;

  task automatic report_fail(input string what);
    if (err_cnt < 40) $display("mismatch at cycle %0d: %s", cyc, what);
    err_cnt++;
  endtask

  function automatic logic gear_moving();
    return gear_m == GEAR_OPENING || gear_m == GEAR_CLOSING;
  endfunction

  // motion ends: the moving state turns into its end position
  function automatic void gear_settle();
    if (gear_m == GEAR_CLOSING) begin
      gear_m = GEAR_CLOSED;
      if (phase_m == PH_FIRST) phase_m = PH_DONE;
    end else if (gear_m == GEAR_OPENING) begin
      gear_m = GEAR_OPENED;
    end
  endfunction

  function automatic void gear_halt();
    if (gear_moving()) begin
      pins_m  = '0;
      sense_m = 1'b0;
      gear_settle();
    end
  endfunction

  // the same request again keeps its delay count running
  function automatic void gear_ask(req_e r);
    if (r != req_m) begin
      req_cnt = '0;
      req_m   = r;
    end
  endfunction

  function automatic result_t gear_predict(item_t it);
    logic fire;
    result_t r;
    case (it.op)
      OP_PULSE: begin
        if (!seen_m) begin
          first_m = it.pw;
          seen_m  = 1'b1;
        end
        last_m = it.pw;
        // a high first pulse is cleared by a later low one
        if (first_m > cfg_m.open_thr && it.pw < cfg_m.close_thr) first_m = '0;
        if (first_m < cfg_m.close_thr && (phase_m == PH_DONE || phase_m == PH_IDLE)) begin
          case (gear_m)
            GEAR_INIT: begin
              if (phase_m == PH_IDLE) begin
                phase_m = PH_FIRST;
                gear_ask(REQ_CLOSE);
              end
            end
            GEAR_OPENED: if (it.pw < cfg_m.close_thr) gear_ask(REQ_CLOSE);
            GEAR_CLOSED: if (it.pw > cfg_m.open_thr) gear_ask(REQ_OPEN);
            GEAR_OPENING: begin
              if (it.pw < cfg_m.close_thr) begin
                gear_halt();
                gear_ask(REQ_CLOSE);
              end
            end
            default: begin
              if (it.pw > cfg_m.open_thr) begin
                gear_halt();
                gear_ask(REQ_OPEN);
              end
            end
          endcase
        end
      end
      OP_TICK: begin
        if (req_m == REQ_OPEN || req_m == REQ_CLOSE) begin
          fire = req_cnt > cfg_m.req_delay;
          if (req_cnt != CNT9_MAX) req_cnt = req_cnt + 9'd1;
          if (fire) begin
            mot_cnt = '0;
            sense_m = 1'b1;
            if (req_m == REQ_CLOSE) begin
              gear_m = GEAR_CLOSING;
              pins_m = PINS_CLOSE;
            end else begin
              gear_m = GEAR_OPENING;
              pins_m = PINS_OPEN;
            end
            req_m = REQ_NONE;
          end
        end
        if (gear_moving()) begin
          if (mot_cnt != CNT16_MAX) mot_cnt = mot_cnt + 16'd1;
          if (mot_cnt >= cfg_m.timeout) gear_halt();
        end
        // neutral band means the radio link is lost
        if (last_m < cfg_m.neu_high && last_m > cfg_m.neu_low) begin
          if (lost_cnt > cfg_m.fs_ticks) begin
            if (req_m != REQ_CLOSE && gear_m != GEAR_CLOSING && gear_m != GEAR_CLOSED) begin
              gear_halt();
              gear_ask(REQ_CLOSE);
            end
          end else if (lost_cnt != CNT9_MAX) begin
            lost_cnt = lost_cnt + 9'd1;
          end
        end else begin
          lost_cnt = '0;
        end
      end
      OP_FAULT: begin
        pins_m = pins_m & (it.arm ? PINS_ARM1 : PINS_ARM2);
        if (pins_m == '0) begin
          sense_m = 1'b0;
          gear_settle();
        end
      end
      default: begin
        if (gear_m == GEAR_INIT && phase_m == PH_IDLE) begin
          phase_m = PH_FIRST;
          gear_ask(REQ_CLOSE);
        end
      end
    endcase
    r.gear    = gear_m;
    r.pins    = pins_m;
    r.sense   = sense_m;
    r.pending = req_m;
    r.phase   = phase_m;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_event(op_e op, logic [15:0] pw, logic arm);
    item_t it;
    it.op  = op;
    it.pw  = pw;
    it.arm = arm;
    event_q.push_back(it);
  endfunction

  // pulse widths placed relative to the thresholds now in force
  function automatic logic [15:0] rand_pulse(int kind);
    int cl;
    int op;
    int nl;
    int nh;
    cl = int'(cfg_m.close_thr);
    op = int'(cfg_m.open_thr);
    nl = int'(cfg_m.neu_low);
    nh = int'(cfg_m.neu_high);
    case (kind)
      0: return (cl == 0) ? 16'd0 : 16'($urandom_range(0, cl - 1));
      1: return (op == 65535) ? 16'hFFFF : 16'($urandom_range(op + 1, 65535));
      2: return (nh > nl + 1) ? 16'($urandom_range(nl + 1, nh - 1)) : 16'(nl);
      3: return 16'($urandom);
      4: return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
      default: begin
        case ($urandom_range(0, 3))
          0: return cfg_m.close_thr;
          1: return cfg_m.open_thr;
          2: return cfg_m.neu_low;
          default: return cfg_m.neu_high;
        endcase
      end
    endcase
  endfunction

  // ticks carry random junk in the unused fields
  function automatic void push_ticks(int n);
    for (int k = 0; k < n; k++) push_event(OP_TICK, 16'($urandom), 1'($urandom));
  endfunction

  // one well-formed sequence with random content, or a burst of noise
  function automatic void push_scenario();
    int fire_ticks;
    int span;
    int n;
    logic dir;
    fire_ticks = int'(cfg_m.req_delay) + 2;
    span = (int'(cfg_m.timeout) + 3 > 70) ? 70 : int'(cfg_m.timeout) + 3;
    dir = 1'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // open or close request, wait it out, then let it run or time out
        push_event(OP_PULSE, rand_pulse(dir ? 1 : 0), 1'($urandom));
        n = fire_ticks + $urandom_range(0, span);
        push_ticks(n > 400 ? 400 : n);
      end
      4: begin
        // reverse while moving
        push_event(OP_PULSE, rand_pulse(dir ? 1 : 0), 1'($urandom));
        push_ticks(fire_ticks + $urandom_range(0, 4));
        push_event(OP_PULSE, rand_pulse(dir ? 0 : 1), 1'($urandom));
        push_ticks(fire_ticks + $urandom_range(0, span));
      end
      5: begin
        // overcurrent on one arm or both during motion
        push_event(OP_PULSE, rand_pulse(dir ? 1 : 0), 1'($urandom));
        push_ticks(fire_ticks + $urandom_range(0, 3));
        n = $urandom_range(0, 1);
        push_event(OP_FAULT, 16'($urandom), 1'(n));
        if ($urandom_range(0, 2) != 0) push_event(OP_FAULT, 16'($urandom), 1'(~n));
        push_ticks($urandom_range(0, 5));
      end
      6: begin
        // neutral held long enough for the failsafe close
        push_event(OP_PULSE, rand_pulse(2), 1'($urandom));
        n = int'(cfg_m.fs_ticks) + $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 15) == 0) push_event(OP_PULSE, rand_pulse(2), 1'($urandom));
          else push_event(OP_TICK, 16'($urandom), 1'($urandom));
        end
        push_ticks(fire_ticks + $urandom_range(0, span));
      end
      7: begin
        push_event(OP_STARTUP, 16'($urandom), 1'($urandom));
        push_ticks($urandom_range(1, fire_ticks + 4));
      end
      default: begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
          push_event(op_e'($urandom_range(0, 3)), rand_pulse($urandom_range(0, 5)),
                     1'($urandom));
      end
    endcase
  endfunction

  // register write; the shadow settings follow the same write
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_CLOSE_THR: cfg_m.close_thr = data;
      CFG_OPEN_THR:  cfg_m.open_thr  = data;
      CFG_NEU_LOW:   cfg_m.neu_low   = data;
      CFG_NEU_HIGH:  cfg_m.neu_high  = data;
      CFG_REQ_DELAY: cfg_m.req_delay = data[7:0];
      CFG_FS_TICKS:  cfg_m.fs_ticks  = data[7:0];
      CFG_TIMEOUT:   cfg_m.timeout   = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // fill the event queue to n items, send them, and wait until all status is back
  // the check runs at the falling edge so the driver's updates are settled
  task automatic play_events(input int n, input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    while (event_q.size() < n) push_scenario();
    @(negedge clk_i);
    while (event_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued events, holds them until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    item_t nxt;
    logic  idle;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        status_q.push_back(gear_predict(item_t'({s_axis_tuser, s_axis_tdata[15:0],
                                                 s_axis_tdata[16]})));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_burst > 0) tx_burst--;
        else if ($urandom_range(0, 99) < 2) tx_burst = $urandom_range(10, 40);
        idle = (tx_burst == 0) && ($urandom_range(0, 99) < tx_idle_pct);
        if (event_q.size() != 0 && !idle) begin
          nxt = event_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, nxt.arm, nxt.pw};
          s_axis_tuser  <= nxt.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every accepted status word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[11:0]);
        if (status_q.size() == 0) begin
          report_fail($sformatf("status 0x%0h with nothing expected", m_axis_tdata));
        end else begin
          want = status_q.pop_front();
          if (got.gear != want.gear)
            report_fail($sformatf("gear_state got %0d want %0d", got.gear, want.gear));
          if (got.pins != want.pins)
            report_fail($sformatf("motor_pins got %h want %h", got.pins, want.pins));
          if (got.sense != want.sense)
            report_fail($sformatf("sense_enable got %0d want %0d", got.sense, want.sense));
          if (got.pending != want.pending)
            report_fail($sformatf("pending_request got %0d want %0d",
                                  got.pending, want.pending));
          if (got.phase != want.phase)
            report_fail($sformatf("startup_phase got %0d want %0d", got.phase, want.phase));
        end
      end
      if (rx_burst > 0) rx_burst--;
      else if ($urandom_range(0, 99) < 2) rx_burst = $urandom_range(10, 40);
      m_axis_tready <= (rx_burst != 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // watchdog
  initial begin
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_PULSE;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_CLOSE_THR;
    cfg_data_i    = '0;
    err_cnt       = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    tx_burst      = 0;
    rx_burst      = 0;

    cfg_m    = CFG_RESET;
    gear_m   = GEAR_INIT;
    pins_m   = '0;
    sense_m  = 1'b0;
    req_m    = REQ_NONE;
    req_cnt  = '0;
    mot_cnt  = '0;
    lost_cnt = '0;
    phase_m  = PH_IDLE;
    seen_m   = 1'b0;
    first_m  = '0;
    last_m   = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle gear, stops while still, gated first pulse, startup close
    push_event(OP_TICK, 16'hFFFF, 1'b1);
    push_event(OP_FAULT, 16'd0, 1'b0);
    push_event(OP_FAULT, 16'hFFFF, 1'b1);
    push_event(OP_PULSE, 16'hFFFF, 1'b0);     // first pulse high: requests gated
    push_event(OP_STARTUP, 16'd0, 1'b0);      // forces the first close
    push_event(OP_STARTUP, 16'hFFFF, 1'b1);   // already started: ignored
    push_event(OP_PULSE, 16'd0, 1'b1);        // low pulse clears the high first pulse
    push_ticks(7);                            // close fires once the delay is passed
    push_event(OP_FAULT, 16'd0, 1'b0);        // arm one stops, arm two still driven
    push_event(OP_FAULT, 16'd0, 1'b1);        // all pins low: closed, startup done
    push_event(OP_PULSE, 16'hFFFF, 1'b0);     // open request
    push_event(OP_PULSE, 16'd65000, 1'b0);    // same request again
    push_ticks(3);
    push_event(OP_PULSE, 16'd1200, 1'b0);     // exactly on the close threshold
    push_event(OP_PULSE, 16'd0, 1'b0);        // closed: low pulse does nothing
    push_event(OP_TICK, 16'd0, 1'b0);
    play_events(320, 0, 0);

    // shortest delays and timeout
    cfg_write(CFG_REQ_DELAY, 16'd0);
    cfg_write(CFG_FS_TICKS, 16'd0);
    cfg_write(CFG_TIMEOUT, 16'd1);
    play_events(300, 83, 0);

    // longest delays, motion never times out
    cfg_write(CFG_REQ_DELAY, 16'd255);
    cfg_write(CFG_FS_TICKS, 16'd255);
    cfg_write(CFG_TIMEOUT, 16'hFFFF);
    play_events(500, 0, 83);

    // thresholds at the far ends: almost every pulse requests and is neutral
    cfg_write(CFG_CLOSE_THR, 16'hFFFF);
    cfg_write(CFG_OPEN_THR, 16'd0);
    cfg_write(CFG_NEU_LOW, 16'd0);
    cfg_write(CFG_NEU_HIGH, 16'hFFFF);
    cfg_write(CFG_REQ_DELAY, 16'd2);
    cfg_write(CFG_FS_TICKS, 16'd3);
    cfg_write(CFG_TIMEOUT, 16'd10);
    play_events(250, 26, 26);

    // random but sensible settings, plus a write to the unused index
    cfg_write(CFG_CLOSE_THR, 16'($urandom_range(1000, 30000)));
    cfg_write(CFG_OPEN_THR, 16'($urandom_range(int'(cfg_m.close_thr), 60000)));
    cfg_write(CFG_NEU_LOW, 16'($urandom_range(int'(cfg_m.close_thr), int'(cfg_m.open_thr))));
    cfg_write(CFG_NEU_HIGH, 16'($urandom_range(int'(cfg_m.neu_low), int'(cfg_m.open_thr))));
    cfg_write(CFG_REQ_DELAY, 16'($urandom_range(0, 20)));
    cfg_write(CFG_FS_TICKS, 16'($urandom_range(0, 40)));
    cfg_write(CFG_TIMEOUT, 16'($urandom_range(1, 80)));
    cfg_write(CFG_SPARE, 16'($urandom));
    play_events(300, 83, 83);

    // close threshold at zero: nothing below it, pulses gated off
    cfg_write(CFG_CLOSE_THR, 16'd0);
    cfg_write(CFG_OPEN_THR, 16'hFFFF);
    cfg_write(CFG_NEU_LOW, 16'd1450);
    cfg_write(CFG_NEU_HIGH, 16'd1550);
    cfg_write(CFG_REQ_DELAY, 16'd1);
    cfg_write(CFG_FS_TICKS, 16'd5);
    cfg_write(CFG_TIMEOUT, 16'd20);
    play_events(150, 26, 26);

    if (status_q.size() != 0)
      report_fail($sformatf("%0d status words never arrived", status_q.size()));

    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rgc_pkg.sv
sv/rgc_cfg.sv
sv/rgc_step.sv
sv/retract_gear_controller.sv
sv/rgc_checker.sv
tb/tb.sv
